@@ rtl/core/ttsa_pkg.sv @@
package ttsa_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CountW  = 8;

  localparam logic [CfgW-1:0] CountMax = 9'd256;

  localparam logic [CfgIdxW-1:0] RegTilesAcross = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTilesDown   = 2'd1;

endpackage

@@ rtl/core/tile_transpose_with_scatter_address_top.sv @@
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  row_word_i
// out       output     out_valid_o/out_stall_i column_word_o, dest_address_o, tile_end_o
// cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One row transfer per cycle in, one column transfer per cycle out, unless stalled.
// Two tile buffers alternate: one fills while the other drains.
// The last row sets full_q; the first column read is then registered to the outputs.
// in_stall_o rises only when both tile buffers hold undrained tiles.
// Reset clears counters and buffer flags; no clearing pass is needed.
module tile_transpose_with_scatter_address_top #(
  parameter int unsigned ELEMS     = 4,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttsa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ttsa_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ttsa_pkg::WordW-1:0]      row_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ttsa_pkg::WordW-1:0]      column_word_o,
  output logic [ttsa_pkg::AddrW-1:0]      dest_address_o,
  output logic                            tile_end_o
);

  localparam int unsigned RW = $clog2(ELEMS);
  localparam int unsigned AW = ttsa_pkg::AddrW;
  localparam int unsigned CW = ttsa_pkg::CfgW;
  localparam int unsigned NW = ttsa_pkg::CountW;

  function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > ttsa_pkg::CountMax) begin
      r = ttsa_pkg::CountMax;
    end
    return r;
  endfunction

  logic [CW-1:0] across_q, down_q;
  logic [AW-1:0] span_q;
  logic [CW-1:0] cfg_eff;

  logic [RW-1:0] row_q;
  logic          wr_bank_q;
  logic [1:0]    full_q, full_d;
  logic [NW-1:0] ty_q, tz_q;
  logic [AW-1:0] base_q [2];
  logic [CW-1:0] step_q [2];
  logic [AW-1:0] base_d;

  logic          rd_bank_q;
  logic [RW-1:0] col_q;
  logic [AW-1:0] acc_q, addr_cur;
  logic          out_valid_q, out_end_q;
  logic [AW-1:0] out_addr_q;

  logic in_xfer, last_row, rd_issue, last_col;

  assign cfg_eff = eff_count(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= CW'(1);
      down_q   <= CW'(1);
      span_q   <= AW'(ELEMS);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ttsa_pkg::RegTilesAcross: begin
          across_q <= cfg_eff;
          span_q   <= AW'(cfg_eff) * AW'(ELEMS);
        end
        ttsa_pkg::RegTilesDown: down_q <= cfg_eff;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full_q[wr_bank_q];
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign last_row   = (row_q == RW'(ELEMS - 1));
  assign base_d     = AW'(tz_q) * span_q + AW'(ty_q);

  assign rd_issue = full_q[rd_bank_q] & (~out_valid_q | ~out_stall_i);
  assign last_col = (col_q == RW'(ELEMS - 1));
  assign addr_cur = (col_q == '0) ? base_q[rd_bank_q] : acc_q;

  always_comb begin
    full_d = full_q;
    if (in_xfer && last_row) begin
      full_d[wr_bank_q] = 1'b1;
    end
    if (rd_issue && last_col) begin
      full_d[rd_bank_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      wr_bank_q <= 1'b0;
      full_q    <= '0;
      ty_q      <= '0;
      tz_q      <= '0;
    end else begin
      full_q <= full_d;
      if (in_xfer) begin
        if (last_row) begin
          row_q     <= '0;
          wr_bank_q <= ~wr_bank_q;
          if ({1'b0, ty_q} + CW'(1) >= across_q) begin
            ty_q <= '0;
            if ({1'b0, tz_q} + CW'(1) >= down_q) begin
              tz_q <= '0;
            end else begin
              tz_q <= tz_q + NW'(1);
            end
          end else begin
            ty_q <= ty_q + NW'(1);
          end
        end else begin
          row_q <= row_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_row) begin
      base_q[wr_bank_q] <= base_d;
      step_q[wr_bank_q] <= across_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_bank_q   <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_issue) begin
        out_valid_q <= 1'b1;
        if (last_col) begin
          col_q     <= '0;
          rd_bank_q <= ~rd_bank_q;
        end else begin
          col_q <= col_q + RW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      out_addr_q <= addr_cur;
      out_end_q  <= last_col;
      acc_q      <= addr_cur + AW'(step_q[rd_bank_q]);
    end
  end

  ttsa_tile_buf #(
    .ELEMS     (ELEMS),
    .ELEM_BITS (ELEM_BITS)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer),
    .wr_bank_i (wr_bank_q),
    .wr_row_i  (row_q),
    .wr_word_i (row_word_i),
    .rd_en_i   (rd_issue),
    .rd_bank_i (rd_bank_q),
    .rd_col_i  (col_q),
    .rd_word_o (column_word_o)
  );

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_addr_q;
  assign tile_end_o     = out_end_q;

`ifndef SYNTH
  a_both_full_banks_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q == 2'b11) |-> (wr_bank_q == rd_bank_q))
    else $error("both buffers full with write and read banks apart");

  a_drain_from_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != '0) |-> full_q[rd_bank_q])
    else $error("column drain in progress on a buffer not marked full");

  a_fill_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != '0) |-> !full_q[wr_bank_q])
    else $error("partial tile fill on a buffer marked full");

  a_last_col_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue && last_col) |=> (out_valid_o && tile_end_o))
    else $error("last column read without tile end on output");
`endif

endmodule

@@ rtl/core/ttsa_tile_buf.sv @@
module ttsa_tile_buf #(
  parameter int unsigned ELEMS     = 4,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic                           wr_bank_i,
  input  logic [$clog2(ELEMS)-1:0]       wr_row_i,
  input  logic [ttsa_pkg::WordW-1:0]     wr_word_i,
  input  logic                           rd_en_i,
  input  logic                           rd_bank_i,
  input  logic [$clog2(ELEMS)-1:0]       rd_col_i,
  output logic [ttsa_pkg::WordW-1:0]     rd_word_o
);

  localparam int unsigned RW    = $clog2(ELEMS);
  localparam int unsigned Depth = 2 * ELEMS;
  localparam int unsigned AW    = $clog2(Depth);

  logic [ELEM_BITS-1:0] mem_q [ELEMS][Depth];
  logic [ELEM_BITS-1:0] rd_data_q [ELEMS];
  logic [RW-1:0]        rd_col_q;

  logic [ELEMS-1:0][AW-1:0]        wr_addr;
  logic [ELEMS-1:0][ELEM_BITS-1:0] wr_data;
  logic [AW-1:0]                   rd_addr;

  // lane l of row r holds element (l - r) mod ELEMS at that element's column slot
  always_comb begin
    logic [RW:0]   sum;
    logic [RW-1:0] j;
    for (int l = 0; l < ELEMS; l++) begin
      sum = (RW+1)'(l) + (RW+1)'(ELEMS) - {1'b0, wr_row_i};
      if (sum >= (RW+1)'(ELEMS)) begin
        sum = sum - (RW+1)'(ELEMS);
      end
      j = sum[RW-1:0];
      wr_addr[l] = wr_bank_i ? AW'(ELEMS) + AW'(j) : AW'(j);
      wr_data[l] = wr_word_i[int'(j)*ELEM_BITS +: ELEM_BITS];
    end
  end

  assign rd_addr = rd_bank_i ? AW'(ELEMS) + AW'(rd_col_i) : AW'(rd_col_i);

  for (genvar l = 0; l < ELEMS; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (wr_en_i) begin
        mem_q[l][wr_addr[l]] <= wr_data[l];
      end
      if (rd_en_i) begin
        rd_data_q[l] <= mem_q[l][rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_col_q <= rd_col_i;
    end
  end

  // row r of the column sits in lane (col + r) mod ELEMS
  always_comb begin
    logic [RW:0] lane;
    rd_word_o = '0;
    for (int r = 0; r < ELEMS; r++) begin
      lane = {1'b0, rd_col_q} + (RW+1)'(r);
      if (lane >= (RW+1)'(ELEMS)) begin
        lane = lane - (RW+1)'(ELEMS);
      end
      rd_word_o[r*ELEM_BITS +: ELEM_BITS] = rd_data_q[lane[RW-1:0]];
    end
  end

endmodule
